FILE: rtl/gcd_pkg.sv
package gcd_pkg;

  // Angles are degrees with one more fraction bit than the ports, so half gaps are exact.
  localparam int ANG_FRAC = 16;
  localparam int ANG_G    = ANG_FRAC + 1;
  localparam int ANG_W    = 26;
  localparam int MAG_W    = 24;
  localparam int CS_W     = 33;
  localparam int SQ_STEPS = 31;
  localparam int RAD_W    = 24;
  localparam int DIST_W   = 24;

  localparam logic signed [ANG_W-1:0] LAT_LIMIT = ANG_W'(90 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] LAT_WRAP  = ANG_W'(180 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] LON_LIMIT = ANG_W'(180 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] LON_WRAP  = ANG_W'(360 << ANG_FRAC);

  localparam logic signed [ANG_W:0] FULL_TURN    = (ANG_W + 1)'(360 << ANG_G);
  localparam logic signed [ANG_W:0] HALF_TURN    = (ANG_W + 1)'(180 << ANG_G);
  localparam logic signed [ANG_W:0] QUARTER_TURN = (ANG_W + 1)'(90 << ANG_G);

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [26:0]            DEG_TO_RAD  = 27'd74961321;
  localparam logic [30:0]            ONE_Q30     = 31'd1 << 30;
  localparam logic [RAD_W-1:0]       RADIUS_RESET = 24'd1013734;
  localparam logic [DIST_W-1:0]      DIST_MAX    = 24'hFFFFFF;

  function automatic logic signed [CS_W-1:0] atan_q30(input int unsigned i);
    logic signed [CS_W-1:0] r;
    case (i)
      0: r = 33'sd843314857;
      1: r = 33'sd497837829;
      2: r = 33'sd263043837;
      3: r = 33'sd133525159;
      4: r = 33'sd67021687;
      5: r = 33'sd33543516;
      6: r = 33'sd16775851;
      7: r = 33'sd8388437;
      8: r = 33'sd4194283;
      9: r = 33'sd2097149;
      default: begin
        if (i <= 30) r = (33'sd1 <<< (30 - i)) - 33'sd1;
        else r = '0;
      end
    endcase
    return r;
  endfunction

  // Q30 product, rounded half up, shift rounds toward minus infinity.
  function automatic logic signed [CS_W-1:0] mul_q30(input logic signed [CS_W-1:0] a,
                                                      input logic signed [CS_W-1:0] b);
    logic signed [2*CS_W-1:0] p;
    p = a * b + (66'sd1 <<< 29);
    return $signed(p[62:30]);
  endfunction

endpackage

FILE: rtl/gcd_sincos.sv
module gcd_sincos #(
  parameter int ITER = 24
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [gcd_pkg::ANG_W-1:0] ang_i,
  output logic signed [gcd_pkg::CS_W-1:0]  sin_o,
  output logic signed [gcd_pkg::CS_W-1:0]  cos_o
);
  import gcd_pkg::*;

  logic signed [ANG_W:0]  r;
  logic                   nc_d;
  logic [MAG_W-1:0]       mag_d, mag_q;
  logic                   neg_d, neg_q, nca_q, ncb_q;
  logic [51:0]            prod;
  logic [30:0]            scl;
  logic signed [CS_W-1:0] zb_d, zb_q;
  logic signed [CS_W-1:0] x_q [ITER];
  logic signed [CS_W-1:0] y_q [ITER];
  logic signed [CS_W-1:0] z_q [ITER];
  logic                   nc_q [ITER];

  // Reduce to one turn around zero, then fold into the right half plane.
  always_comb begin
    r = {ang_i[ANG_W-1], ang_i};
    nc_d = 1'b0;
    if (r >= HALF_TURN) r = r - FULL_TURN;
    else if (r < -HALF_TURN) r = r + FULL_TURN;
    if (r > QUARTER_TURN) begin
      r = HALF_TURN - r;
      nc_d = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r = -HALF_TURN - r;
      nc_d = 1'b1;
    end
    neg_d = r[ANG_W];
    mag_d = neg_d ? MAG_W'(-r) : MAG_W'(r);
  end

  always_comb begin
    prod = 52'(mag_q) * 52'(DEG_TO_RAD) + (52'd1 << (ANG_G + 1));
    scl  = prod[ANG_G+32:ANG_G+2];
    zb_d = neg_q ? -$signed({2'b00, scl}) : $signed({2'b00, scl});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      nca_q <= nc_d;
      zb_q  <= zb_d;
      ncb_q <= nca_q;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    localparam logic signed [CS_W-1:0] ATAN = atan_q30(i);
    logic signed [CS_W-1:0] xi, yi, zi;
    logic                   nci;
    if (i == 0) begin : g_first
      assign xi  = CORDIC_GAIN;
      assign yi  = '0;
      assign zi  = zb_q;
      assign nci = ncb_q;
    end else begin : g_next
      assign xi  = x_q[i-1];
      assign yi  = y_q[i-1];
      assign zi  = z_q[i-1];
      assign nci = nc_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zi[CS_W-1]) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - ATAN;
        end else begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + ATAN;
        end
        nc_q[i] <= nci;
      end
    end
  end

  assign sin_o = y_q[ITER-1];
  assign cos_o = nc_q[ITER-1] ? -x_q[ITER-1] : x_q[ITER-1];

endmodule

FILE: rtl/gcd_isqrt.sv
module gcd_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [60:0] val_i,
  output logic [30:0] root_o
);
  import gcd_pkg::*;

  logic [60:0] rem_q [SQ_STEPS];
  logic [63:0] res_q [SQ_STEPS];

  // One result bit per stage, from the top digit pair down.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_dig
    localparam logic [63:0] BIT = 64'd1 << (60 - 2 * k);
    logic [60:0] remi;
    logic [63:0] resi, trial;
    if (k == 0) begin : g_first
      assign remi = val_i;
      assign resi = '0;
    end else begin : g_next
      assign remi = rem_q[k-1];
      assign resi = res_q[k-1];
    end
    assign trial = resi + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({3'b000, remi} >= trial) begin
          rem_q[k] <= remi - trial[60:0];
          res_q[k] <= (resi >> 1) + BIT;
        end else begin
          rem_q[k] <= remi;
          res_q[k] <= resi >> 1;
        end
      end
    end
  end

  assign root_o = res_q[SQ_STEPS-1][30:0];

endmodule

FILE: rtl/gcd_atan.sv
module gcd_atan #(
  parameter int ITER = 24
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [30:0]                     y_i,
  input  logic [30:0]                     x_i,
  output logic signed [gcd_pkg::CS_W-1:0] ang_o
);
  import gcd_pkg::*;

  logic signed [33:0]     x_q [ITER];
  logic signed [33:0]     y_q [ITER];
  logic signed [CS_W-1:0] z_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_vec
    localparam logic signed [CS_W-1:0] ATAN = atan_q30(i);
    logic signed [33:0]     xi, yi;
    logic signed [CS_W-1:0] zi;
    if (i == 0) begin : g_first
      assign xi = $signed({3'b000, x_i});
      assign yi = $signed({3'b000, y_i});
      assign zi = '0;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!yi[33]) begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + ATAN;
        end else begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - ATAN;
        end
      end
    end
  end

  assign ang_o = z_q[ITER-1];

endmodule

FILE: rtl/great_circle_distance.sv
// Channel   Direction  Payload
// s_axis    in         point pair: two latitudes and two longitudes with hemisphere flags
// m_axis    out        distance, 1/256 mile, saturated
// cfg       in         sphere radius, 1/256 mile
//
// One point pair enters per cycle while the skid register is empty; the latency is set by
// the two CORDIC chains and the 31 digit stages of the square roots.
// Reset clears the valid bits, including those of the output buffer, and sets the
// radius to 3959.9 miles.
// All stages move together; a stalled output parks one result in a skid register,
// and the input stops only while that register is full.
module great_circle_distance #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [22:0] first_lat_deg, [23] first_lat_south, [46:24] second_lat_deg,
  // [47] second_lat_south, [71:48] first_lon_deg, [72] first_lon_west,
  // [96:73] second_lon_deg, [97] second_lon_west, [103:98] zero
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [23:0] distance
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [23:0]  cfg_data_i
);
  import gcd_pkg::*;

  localparam int VLEN = 2 * CORDIC_ITERATIONS + 38;

  function automatic logic signed [ANG_W-1:0] gap(input logic [23:0] m1, input logic f1,
                                                   input logic [23:0] m2, input logic f2,
                                                   input logic signed [ANG_W-1:0] lim,
                                                   input logic signed [ANG_W-1:0] wrap);
    logic signed [ANG_W-1:0] a, b, s;
    a = $signed({2'b00, m1});
    b = $signed({2'b00, m2});
    if (f1 == f2) begin
      s = a - b;
    end else begin
      s = a + b;
      if (s > lim) s = wrap - s;
    end
    return s;
  endfunction

  logic                    adv;
  logic [VLEN-1:0]         v_q;
  logic [RAD_W-1:0]        radius_q;
  logic signed [ANG_W-1:0] glat_q, glon_q, dbl1_q, dbl2_q;
  logic signed [CS_W-1:0]  slat, slon, c1, c2, sin_nu1, sin_nu2, cos_nu1, cos_nu2;
  logic signed [CS_W-1:0]  sqlat_q, c12_q, sqlon_q, sqlat2_q, t_q;
  logic signed [CS_W:0]    asum;
  logic [30:0]             a_cl;
  logic [60:0]             ysq_q, xsq_q;
  logic [30:0]             yroot, xroot;
  logic signed [CS_W-1:0]  zang;
  logic [31:0]             zc;
  logic [55:0]             prod_q;
  logic [56:0]             rnd;
  logic [DIST_W-1:0]       dist_sat;
  logic                    push, pop;
  logic                    out_v_q, sk_v_q;
  logic [DIST_W-1:0]       out_q, sk_q;

  assign adv           = !sk_v_q;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[VLEN-2:0], s_axis_tvalid};
    end
  end

  // Gap stage. Cosines take the latitudes doubled, in the same half-degree scale.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      glat_q <= gap({1'b0, s_axis_tdata[22:0]}, s_axis_tdata[23],
                    {1'b0, s_axis_tdata[46:24]}, s_axis_tdata[47], LAT_LIMIT, LAT_WRAP);
      glon_q <= gap(s_axis_tdata[71:48], s_axis_tdata[72],
                    s_axis_tdata[96:73], s_axis_tdata[97], LON_LIMIT, LON_WRAP);
      dbl1_q <= $signed({2'b00, s_axis_tdata[22:0], 1'b0});
      dbl2_q <= $signed({2'b00, s_axis_tdata[46:24], 1'b0});
    end
  end

  gcd_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_lat (
    .clk_i, .en_i(adv), .ang_i(glat_q), .sin_o(slat), .cos_o(cos_nu1));
  gcd_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_lon (
    .clk_i, .en_i(adv), .ang_i(glon_q), .sin_o(slon), .cos_o(cos_nu2));
  gcd_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_p1 (
    .clk_i, .en_i(adv), .ang_i(dbl1_q), .sin_o(sin_nu1), .cos_o(c1));
  gcd_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_p2 (
    .clk_i, .en_i(adv), .ang_i(dbl2_q), .sin_o(sin_nu2), .cos_o(c2));

  always_comb begin
    asum = $signed({sqlat2_q[CS_W-1], sqlat2_q}) + $signed({t_q[CS_W-1], t_q});
    if (asum[CS_W]) a_cl = '0;
    else if (asum > $signed({3'b000, ONE_Q30})) a_cl = ONE_Q30;
    else a_cl = asum[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqlat_q  <= mul_q30(slat, slat);
      c12_q    <= mul_q30(c1, c2);
      sqlon_q  <= mul_q30(slon, slon);
      sqlat2_q <= sqlat_q;
      t_q      <= mul_q30(c12_q, sqlon_q);
      ysq_q    <= {a_cl, 30'd0};
      xsq_q    <= {ONE_Q30 - a_cl, 30'd0};
    end
  end

  gcd_isqrt u_sqrt_y (.clk_i, .en_i(adv), .val_i(ysq_q), .root_o(yroot));
  gcd_isqrt u_sqrt_x (.clk_i, .en_i(adv), .val_i(xsq_q), .root_o(xroot));

  gcd_atan #(.ITER(CORDIC_ITERATIONS)) u_atan (
    .clk_i, .en_i(adv), .y_i(yroot), .x_i(xroot), .ang_o(zang));

  assign zc = zang[CS_W-1] ? '0 : {zang[30:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (adv) prod_q <= 56'(radius_q) * 56'(zc);
  end

  always_comb begin
    rnd      = {1'b0, prod_q} + (57'd1 << 29);
    dist_sat = (rnd[56:30] > 27'(DIST_MAX)) ? DIST_MAX : rnd[53:30];
  end

  assign push = adv && v_q[VLEN-1];
  assign pop  = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (pop) sk_v_q <= 1'b0;
    end else if (push) begin
      if (!out_v_q || pop) out_v_q <= 1'b1;
      else sk_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (pop) out_q <= sk_q;
    end else if (push) begin
      if (!out_v_q || pop) out_q <= dist_sat;
      else sk_q <= dist_sat;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import gcd_pkg::*;

  localparam int LATENCY     = 2 * 24 + 39;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        lon2_west;
    logic [23:0] lon2;
    logic        lon1_west;
    logic [23:0] lon1;
    logic        lat2_south;
    logic [22:0] lat2;
    logic        lat1_south;
    logic [22:0] lat1;
  } point_pair_t;

  // Haversine distance predictor and the queue of distances still owed by the block.
  class distance_scoreboard;
    logic [RAD_W-1:0]  radius;
    logic [DIST_W-1:0] owed_q[$];
    int                errors;
    int                matched;

    function new();
      radius  = RADIUS_RESET;
      errors  = 0;
      matched = 0;
    endfunction

    function longint atan_entry(int i);
      longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return head[i];
      if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
      return 0;
    endfunction

    function void trig(longint v, output longint s, output longint c);
      longint period, half, quarter, r, z, x, y, dx, dy, mag;
      bit     flip, neg;
      period  = 64'sd360 <<< ANG_G;
      half    = 64'sd180 <<< ANG_G;
      quarter = 64'sd90 <<< ANG_G;
      flip    = 0;
      r = v % period;
      if (r < 0) r += period;
      if (r >= half) r -= period;
      if (r > quarter) begin
        r = half - r;
        flip = 1;
      end else if (r < -quarter) begin
        r = -half - r;
        flip = 1;
      end
      neg = r < 0;
      mag = neg ? -r : r;
      mag = (mag * 74961321 + (64'sd1 <<< (ANG_G + 1))) >>> (ANG_G + 2);
      z = neg ? -mag : mag;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_entry(i);
        end else begin
          x += dx; y -= dy; z += atan_entry(i);
        end
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    function longint root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint angle_gap(longint m1, bit f1, longint m2, bit f2, longint lim,
                               longint wrap);
      longint sum;
      if (f1 == f2) return m1 - m2;
      sum = m1 + m2;
      if (sum > (lim <<< ANG_FRAC)) sum = (wrap <<< ANG_FRAC) - sum;
      return sum;
    endfunction

    function void note_request(point_pair_t p);
      longint lat_gap, lon_gap, s_lat, s_lon, c1, c2, spare, a, x, y, z, dx, dy;
      longint unsigned d;
      lat_gap = angle_gap(p.lat1, p.lat1_south, p.lat2, p.lat2_south, 90, 180);
      lon_gap = angle_gap(p.lon1, p.lon1_west, p.lon2, p.lon2_west, 180, 360);
      trig(lat_gap, s_lat, spare);
      trig(lon_gap, s_lon, spare);
      trig(longint'(p.lat1) * 2, spare, c1);
      trig(longint'(p.lat2) * 2, spare, c2);
      a = qmul(s_lat, s_lat) + qmul(qmul(c1, c2), qmul(s_lon, s_lon));
      if (a < 0) a = 0;
      if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
      y = root(longint'(a) << 30);
      x = root(((64'sd1 <<< 30) - a) << 30);
      z = 0;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_entry(i);
        end else begin
          x -= dx; y += dy; z -= atan_entry(i);
        end
      end
      z *= 2;
      if (z < 0) z = 0;
      d = (longint'(radius) * z + (64'sd1 <<< 29)) >> 30;
      if (d > 64'd16777215) d = 64'd16777215;
      owed_q.push_back(d[23:0]);
    endfunction

    function void report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endfunction

    function void check_result(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (owed_q.size() == 0) begin
        report($sformatf("distance %0d arrived with nothing outstanding", got));
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) report($sformatf("distance %0d, predicted %0d", got, want));
      else matched++;
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [23:0]  m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [23:0]  cfg_data = '0;

  distance_scoreboard sb = new();
  bit quiet = 0;
  bit hold_off = 0;
  int cycles = 0;
  int configs = 0;
  int sent = 0;

  always #6 clk = ~clk;

  great_circle_distance dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off while requests keep coming.
  initial begin
    int stall;
    int held;
    stall = 0;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_off && held < 300) begin
        held++;
        m_tready <= 0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 2);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic send_pair(point_pair_t p);
    s_tvalid <= 1;
    s_tdata  <= {6'b0, p};
    do @(posedge clk); while (!s_tready);
    sb.note_request(p);
    sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_radius(logic [23:0] r);
    cfg_valid <= 1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.radius = r;
    configs++;
  endtask

  function automatic point_pair_t mk(int lat1, bit s1, int lat2, bit s2, int lon1, bit w1,
                                     int lon2, bit w2);
    point_pair_t p;
    p.lat1 = 23'(lat1); p.lat1_south = s1; p.lat2 = 23'(lat2); p.lat2_south = s2;
    p.lon1 = 24'(lon1); p.lon1_west = w1; p.lon2 = 24'(lon2); p.lon2_west = w2;
    return p;
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t p;
    p = point_pair_t'(98'({$urandom, $urandom, $urandom, $urandom}));
    // Most pairs stay on the globe; the rest use the full field widths.
    if ($urandom_range(0, 9) != 0) begin
      p.lat1 = 23'($urandom_range(0, 5898240));
      p.lat2 = 23'($urandom_range(0, 5898240));
      p.lon1 = 24'($urandom_range(0, 11796480));
      p.lon2 = 24'($urandom_range(0, 11796480));
    end
    return p;
  endfunction

  task automatic random_block(int n);
    for (int i = 0; i < n; i++) send_pair(random_pair());
  endtask

  localparam int D90 = 90 << 16;
  localparam int D180 = 180 << 16;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed points on the reset radius.
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk(D90, 0, D90, 1, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 0, 0, 0, D180, 1));
    send_pair(mk(0, 0, 0, 0, D180, 0, D180, 1));
    send_pair(mk(60 << 16, 0, 50 << 16, 1, 0, 0, 0, 0));
    send_pair(mk(0, 1, 0, 0, 120 << 16, 1, 100 << 16, 0));
    send_pair(mk(10 << 16, 1, 70 << 16, 1, 170 << 16, 0, 20 << 16, 0));
    send_pair(mk(D90, 1, D90, 1, 11796480, 1, 0, 0));
    send_pair(mk(23'h7FFFFF, 0, 23'h7FFFFF, 1, 24'hFFFFFF, 0, 24'hFFFFFF, 1));
    send_pair(mk(23'h7FFFFF, 1, 0, 0, 24'hFFFFFF, 1, 1, 1));
    send_pair(mk(1, 0, 0, 0, 0, 0, 1, 0));
    send_pair(mk(45 << 16, 0, 45 << 16, 1, 90 << 16, 1, 90 << 16, 0));
    send_pair(mk(23'h555555, 1, 23'h2AAAAA, 0, 24'hAAAAAA, 1, 24'h555555, 0));
    drain();

    write_radius(24'hFFFFFF);
    send_pair(mk(D90, 0, D90, 1, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 0, D180, 0, D180, 1));
    random_block(120);
    drain();

    write_radius(24'd0);
    send_pair(mk(D90, 0, D90, 1, 0, 0, 0, 0));
    random_block(100);
    drain();

    write_radius(24'($urandom));
    random_block(300);
    // Hold the result side off long enough for the pipeline and skid to fill.
    hold_off = 1;
    random_block(400);
    drain();

    write_radius(RADIUS_RESET);
    random_block(760);
    quiet = 1;
    random_block(200);
    drain();

    $display("Sent %0d point pairs, %0d distances matched, %0d radius writes.",
             sent, sb.matched, configs);
    $display("Covered antipodes, hemisphere folds, full-width magnitudes and a long stall.");
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
